/* hdl/r3df_pkg.sv */
// shared types, constants and the crc-24q byte update for the rtcm3 deframer
// no dependencies; used by every module under hdl
`timescale 1ns / 1ps
`default_nettype none

package r3df_pkg;

  localparam int          BYTE_W      = 8;
  localparam int          OFFSET_W    = 11;
  localparam int          LEN_W       = 10;
  localparam int          CRC_W       = 24;
  localparam int          QUEUE_DEPTH = 4;
  localparam int          OUT_DATA_W  = 32;

  localparam logic [7:0]  PREAMBLE    = 8'hD3;
  localparam logic [23:0] CRC_POLY    = 24'h864CFB;

  // what the back end does with a frame byte
  typedef enum logic [1:0] {
    KIND_HEAD   = 2'd0,   // preamble, restarts the crc
    KIND_BODY   = 2'd1,   // header or payload byte, goes into the crc
    KIND_PARITY = 2'd2,   // first or second parity byte
    KIND_LAST   = 2'd3    // final parity byte, compare and close
  } kind_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   frame_byte;
    logic [OFFSET_W-1:0] byte_offset;
    logic [LEN_W-1:0]    payload_length;
    kind_t               kind;
  } q_entry_t;

  // crc-24q over one byte, msb first, no reflection
  function automatic logic [CRC_W-1:0] crc24q_byte(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 16'h0000};
    for (int i = 0; i < 8; i++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* hdl/rtcm3_frame_deframer_crc24q.sv */
// top level of the rtcm3 deframer with crc-24q check
// depends on r3df_pkg, r3df_front, r3df_queue, r3df_back
//
//  channel | direction | tdata (low bit up)                          | tlast     | tuser
//  --------+-----------+---------------------------------------------+-----------+-------
//  in_     | sink      | data_byte[7:0]                              | -         | -
//  out_    | source    | frame_byte[7:0], byte_offset[18:8],         | frame_end | crc_ok
//          |           | payload_length[28:19], zero [31:29]         |           |
//
// one byte per cycle sustained while the output is not stalled; each request passes through
// the queue and then the result register on its way from input to result, and the
// combinational crc-24q byte update in the back end sets the cycle time
// hunting bytes are taken and dropped, so in_tready only falls when the queue is full
// a stalled result holds in the output register while the queue keeps taking bytes
// synchronous reset clears the frame position, queue pointers and result valid;
// no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module rtcm3_frame_deframer_crc24q #(
  parameter int QUEUE_DEPTH = r3df_pkg::QUEUE_DEPTH
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input stream of raw bytes
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [r3df_pkg::BYTE_W-1:0]        in_tdata,   // data_byte
  // frame byte stream
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [r3df_pkg::OUT_DATA_W-1:0]         out_tdata,  // frame_byte, byte_offset,
                                                              // payload_length, zero pad
  output logic                                    out_tlast,  // frame_end
  output logic                                    out_tuser   // crc_ok
);

  r3df_pkg::q_entry_t            push_entry, head;
  logic                          push, pop, q_full, head_valid;
  logic [r3df_pkg::BYTE_W-1:0]   res_byte;
  logic [r3df_pkg::OFFSET_W-1:0] res_offset;
  logic [r3df_pkg::LEN_W-1:0]    res_length;

  // front: hunt and classify, no dependence on the crc
  r3df_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_byte  (in_tdata),
    .q_full   (q_full),
    .in_ready (in_tready),
    .push     (push),
    .entry    (push_entry)
  );

  // decouples input acceptance from output stalls
  r3df_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  // back: crc, parity compare, result register
  r3df_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (res_byte),
    .out_offset (res_offset),
    .out_length (res_length),
    .out_end    (out_tlast),
    .out_crc_ok (out_tuser)
  );

  assign out_tdata = {3'b000, res_length, res_offset, res_byte};

endmodule

`default_nettype wire

/* hdl/r3df_front.sv */
// front end: preamble hunt, frame position and length tracking, byte classification
// depends on r3df_pkg
`timescale 1ns / 1ps
`default_nettype none

module r3df_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic [r3df_pkg::BYTE_W-1:0] in_byte,
  input  wire logic                       q_full,
  output logic                            in_ready,
  output logic                            push,
  output r3df_pkg::q_entry_t              entry
);

  logic [r3df_pkg::OFFSET_W-1:0] pos_r, pos_nxt;
  logic [r3df_pkg::LEN_W-1:0]    len_r, len_nxt;
  logic [r3df_pkg::OFFSET_W-1:0] body_end, frame_end;
  logic                          keep;
  logic                          accept;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign body_end  = {1'b0, len_r} + r3df_pkg::OFFSET_W'(3);
  assign frame_end = {1'b0, len_r} + r3df_pkg::OFFSET_W'(5);

  always_comb begin
    keep                 = 1'b1;
    pos_nxt              = pos_r + 1'b1;
    len_nxt              = len_r;
    entry.frame_byte     = in_byte;
    entry.byte_offset    = pos_r;
    entry.payload_length = len_r;
    entry.kind           = r3df_pkg::KIND_BODY;
    if (pos_r == '0) begin
      // hunting: anything but the preamble is dropped
      keep                 = (in_byte == r3df_pkg::PREAMBLE);
      len_nxt              = '0;
      entry.payload_length = '0;
      entry.kind           = r3df_pkg::KIND_HEAD;
    end else if (pos_r == r3df_pkg::OFFSET_W'(1)) begin
      len_nxt              = {in_byte[1:0], 8'h00};
      entry.payload_length = '0;
    end else if (pos_r == r3df_pkg::OFFSET_W'(2)) begin
      len_nxt              = {len_r[9:8], in_byte};
      entry.payload_length = {len_r[9:8], in_byte};
    end else if (pos_r < body_end) begin
      entry.kind = r3df_pkg::KIND_BODY;
    end else if (pos_r >= frame_end) begin
      entry.kind = r3df_pkg::KIND_LAST;
      pos_nxt    = '0;
      len_nxt    = '0;
    end else begin
      entry.kind = r3df_pkg::KIND_PARITY;
    end
  end

  assign push = accept && keep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      len_r <= '0;
    end else if (push) begin
      pos_r <= pos_nxt;
      len_r <= len_nxt;
    end
  end

  // position never runs past the last parity byte
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= frame_end)
    else $error("frame position beyond last parity byte");

  // a kept preamble while hunting always opens a frame at offset 1
  a_hunt_open: assert property (@(posedge clk) disable iff (!rst_n)
    (push && pos_r == '0) |=> (pos_r == r3df_pkg::OFFSET_W'(1)))
    else $error("preamble did not open a frame");

endmodule

`default_nettype wire

/* hdl/r3df_queue.sv */
// short first-in first-out queue between front and back end
// depends on r3df_pkg for the entry type
`timescale 1ns / 1ps
`default_nettype none

module r3df_queue #(
  parameter int DEPTH = r3df_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire r3df_pkg::q_entry_t push_entry,
  input  wire logic               pop,
  output logic                    full,
  output logic                    head_valid,
  output r3df_pkg::q_entry_t      head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  r3df_pkg::q_entry_t mem_r [DEPTH];
  logic [PW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]      count_r;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

/* hdl/r3df_back.sv */
// back end: running crc-24q, parity capture and the registered result stage
// depends on r3df_pkg
`timescale 1ns / 1ps
`default_nettype none

module r3df_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          head_valid,
  input  wire r3df_pkg::q_entry_t            head,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [r3df_pkg::BYTE_W-1:0]        out_byte,
  output logic [r3df_pkg::OFFSET_W-1:0]      out_offset,
  output logic [r3df_pkg::LEN_W-1:0]         out_length,
  output logic                               out_end,
  output logic                               out_crc_ok
);

  logic [r3df_pkg::CRC_W-1:0]    crc_r, crc_nxt;
  logic [15:0]                   par_r, par_nxt;
  logic                          end_nxt, ok_nxt;
  logic                          valid_r;
  logic [r3df_pkg::BYTE_W-1:0]   byte_r;
  logic [r3df_pkg::OFFSET_W-1:0] offset_r;
  logic [r3df_pkg::LEN_W-1:0]    length_r;
  logic                          end_r, ok_r;

  // result register frees up when empty or being taken
  assign pop = head_valid && (!valid_r || out_ready);

  always_comb begin
    crc_nxt = crc_r;
    par_nxt = par_r;
    end_nxt = 1'b0;
    ok_nxt  = 1'b0;
    case (head.kind)
      r3df_pkg::KIND_HEAD: begin
        crc_nxt = r3df_pkg::crc24q_byte('0, head.frame_byte);
        par_nxt = '0;
      end
      r3df_pkg::KIND_BODY: begin
        crc_nxt = r3df_pkg::crc24q_byte(crc_r, head.frame_byte);
      end
      r3df_pkg::KIND_PARITY: begin
        par_nxt = {par_r[7:0], head.frame_byte};
      end
      r3df_pkg::KIND_LAST: begin
        end_nxt = 1'b1;
        ok_nxt  = (crc_r == {par_r, head.frame_byte});
        crc_nxt = '0;
        par_nxt = '0;
      end
      default: begin
        crc_nxt = crc_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      crc_r   <= '0;
      par_r   <= '0;
    end else begin
      if (pop) begin
        valid_r <= 1'b1;
        crc_r   <= crc_nxt;
        par_r   <= par_nxt;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      byte_r   <= head.frame_byte;
      offset_r <= head.byte_offset;
      length_r <= head.payload_length;
      end_r    <= end_nxt;
      ok_r     <= ok_nxt;
    end
  end

  assign out_valid  = valid_r;
  assign out_byte   = byte_r;
  assign out_offset = offset_r;
  assign out_length = length_r;
  assign out_end    = end_r;
  assign out_crc_ok = ok_r;

  // shortest frame is header plus three parity bytes
  a_end_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && end_r) |-> (offset_r >= r3df_pkg::OFFSET_W'(5)))
    else $error("frame end before offset 5");

  a_ok_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && ok_r) |-> end_r)
    else $error("crc_ok outside frame end");

  // crc state is cleared after closing a frame
  a_crc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.kind == r3df_pkg::KIND_LAST) |=> (crc_r == '0 && par_r == '0))
    else $error("crc state not cleared at frame end");

endmodule

`default_nettype wire

/* bench/deframe_check_pkg.sv */
// frame-byte predictor and result checker for the rtcm3 deframer testbench
// depends on r3df_pkg for widths and the preamble value
`timescale 1ns / 1ps

package deframe_check_pkg;
  import r3df_pkg::*;

  localparam logic [23:0] CRC24Q_POLY = 24'h864CFB;

  // one crc-24q byte step, msb first, bit-serial feedback form
  function automatic logic [23:0] crc24q_step(input logic [23:0] crc, input logic [7:0] b);
    logic [23:0] acc;
    logic        fb;
    acc = crc;
    for (int i = 7; i >= 0; i--) begin
      fb  = acc[23] ^ b[i];
      acc = {acc[22:0], 1'b0};
      if (fb) begin
        acc = acc ^ CRC24Q_POLY;
      end
    end
    return acc;
  endfunction

  class deframe_scoreboard;
    typedef struct packed {
      logic [BYTE_W-1:0]   frame_byte;
      logic [OFFSET_W-1:0] byte_offset;
      logic                frame_end;
      logic                crc_ok;
      logic [LEN_W-1:0]    payload_length;
    } frame_byte_t;

    // deframer state as the block should hold it
    logic [OFFSET_W-1:0] frame_pos;
    logic [LEN_W-1:0]    frame_len;
    logic [CRC_W-1:0]    crc_acc;
    logic [CRC_W-1:0]    parity_acc;
    frame_byte_t         expected_bytes[$];
    int                  mismatches;

    function new();
      frame_pos  = '0;
      frame_len  = '0;
      crc_acc    = '0;
      parity_acc = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    // advance the frame state by one accepted request; queue the frame byte it yields
    function void note_request(input logic [BYTE_W-1:0] b);
      frame_byte_t e;
      e.frame_byte     = b;
      e.byte_offset    = frame_pos;
      e.frame_end      = 1'b0;
      e.crc_ok         = 1'b0;
      e.payload_length = '0;
      if (frame_pos == '0) begin
        // hunting: anything but the preamble is dropped
        if (b != PREAMBLE) begin
          return;
        end
        crc_acc    = crc24q_step('0, b);
        parity_acc = '0;
        frame_len  = '0;
        frame_pos  = OFFSET_W'(1);
      end else if (frame_pos == OFFSET_W'(1)) begin
        // upper six bits are reserved and ignored
        frame_len = {b[1:0], 8'h00};
        crc_acc   = crc24q_step(crc_acc, b);
        frame_pos = OFFSET_W'(2);
      end else if (frame_pos == OFFSET_W'(2)) begin
        frame_len        = frame_len | LEN_W'(b);
        crc_acc          = crc24q_step(crc_acc, b);
        e.payload_length = frame_len;
        frame_pos        = OFFSET_W'(3);
      end else if (int'(frame_pos) < int'(frame_len) + 3) begin
        crc_acc          = crc24q_step(crc_acc, b);
        e.payload_length = frame_len;
        frame_pos        = frame_pos + 1'b1;
      end else begin
        parity_acc       = {parity_acc[15:0], b};
        e.payload_length = frame_len;
        if (int'(frame_pos) >= int'(frame_len) + 5) begin
          e.frame_end = 1'b1;
          e.crc_ok    = (crc_acc == parity_acc);
          frame_pos   = '0;
          frame_len   = '0;
          crc_acc     = '0;
          parity_acc  = '0;
        end else begin
          frame_pos = frame_pos + 1'b1;
        end
      end
      expected_bytes.push_back(e);
    endfunction

    task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
      mismatches++;
    endtask

    task check_result(input logic [31:0] tdata, input logic tlast, input logic tuser);
      frame_byte_t e;
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected frame byte", tdata, 32'h0);
        return;
      end
      e = expected_bytes.pop_front();
      if (tdata[7:0] != e.frame_byte) begin
        report_mismatch("frame_byte", 32'(tdata[7:0]), 32'(e.frame_byte));
      end
      if (tdata[18:8] != e.byte_offset) begin
        report_mismatch("byte_offset", 32'(tdata[18:8]), 32'(e.byte_offset));
      end
      if (tdata[28:19] != e.payload_length) begin
        report_mismatch("payload_length", 32'(tdata[28:19]), 32'(e.payload_length));
      end
      if (tdata[31:29] != 3'b000) begin
        report_mismatch("tdata pad", 32'(tdata[31:29]), 32'h0);
      end
      if (tlast != e.frame_end) begin
        report_mismatch("frame_end", 32'(tlast), 32'(e.frame_end));
      end
      if (tuser != e.crc_ok) begin
        report_mismatch("crc_ok", 32'(tuser), 32'(e.crc_ok));
      end
    endtask
  endclass

endpackage

/* bench/tb_rtcm3_frame_deframer_crc24q.sv */
// top-level testbench for the rtcm3 deframer: streams noise and frames, checks each frame byte
// depends on r3df_pkg, deframe_check_pkg and the rtcm3_frame_deframer_crc24q rtl
`timescale 1ns / 1ps

module tb_rtcm3_frame_deframer_crc24q;
  import r3df_pkg::*;
  import deframe_check_pkg::*;

  localparam int RANDOM_BYTES    = 1800;
  localparam int NUM_PHASES      = 4;
  localparam int MIN_PHASE_BYTES = 100;
  localparam int DRAIN_CYCLES    = 20;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  // idle percentages per phase: none, sender only, receiver only, both lightly
  int gap_by_phase[NUM_PHASES]   = '{0, 51, 0, 14};
  int stall_by_phase[NUM_PHASES] = '{0, 0, 51, 14};
  int gap_pct   = 0;
  int stall_pct = 0;
  int sent      = 0;

  deframe_scoreboard sb;

  rtcm3_frame_deframer_crc24q DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // every accepted frame byte goes to the checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata, out_tlast, out_tuser);
    end
  end

  // one raw byte request; random idle cycles before it, garbage on tdata while idle
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    sb.note_request(b);
    sent++;
  endtask

  // whole frame: preamble, header with given reserved bits, payload, parity
  // fill < 0 means random payload bytes, else every payload byte is fill
  task automatic send_frame(input int plen, input logic [5:0] rsv, input bit bad_crc,
                            input int fill);
    logic [23:0] crc;
    logic [7:0]  b;
    logic [9:0]  len;
    len = plen[9:0];
    crc = crc24q_step(24'h0, PREAMBLE);
    send_byte(PREAMBLE);
    b   = {rsv, len[9:8]};
    crc = crc24q_step(crc, b);
    send_byte(b);
    b   = len[7:0];
    crc = crc24q_step(crc, b);
    send_byte(b);
    for (int i = 0; i < plen; i++) begin
      b   = (fill < 0) ? 8'($urandom) : 8'(fill);
      crc = crc24q_step(crc, b);
      send_byte(b);
    end
    // a corrupted parity flips one bit anywhere in the 24
    if (bad_crc) begin
      crc = crc ^ (24'h1 << $urandom_range(0, 23));
    end
    send_byte(crc[23:16]);
    send_byte(crc[15:8]);
    send_byte(crc[7:0]);
  endtask

  initial begin
    int r;
    int plen;
    int nnoise;
    int phase_end;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: hunting drops extremes and a near-preamble byte
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hD2);
    // zero-length frame, all reserved bits set, good parity
    send_frame(0, 6'h3F, 1'b0, -1);
    // preamble value as payload data, must not restart the frame
    send_frame(1, 6'h00, 1'b0, PREAMBLE);
    // short frame with a corrupted parity
    send_frame(2, 6'h15, 1'b1, -1);

    // random: mostly well-formed frames, some with bad parity, some noise runs
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      gap_pct   = gap_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      // one maximum-length frame, covers the top length bits
      if (ph == 1) begin
        send_frame(1023, 6'($urandom), 1'b0, -1);
      end
      // share what is left of the budget evenly, every phase gets some traffic
      phase_end = sent + (RANDOM_BYTES - sent) / (NUM_PHASES - ph);
      if (phase_end < sent + MIN_PHASE_BYTES) begin
        phase_end = sent + MIN_PHASE_BYTES;
      end
      while (sent < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          nnoise = $urandom_range(1, 4);
          for (int i = 0; i < nnoise; i++) begin
            send_byte(8'($urandom));
          end
        end else begin
          plen = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 30);
          send_frame(plen, 6'($urandom), (r < 30), -1);
        end
      end
    end

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("rtcm3_frame_deframer_crc24q test passed");
    end else begin
      $display("rtcm3_frame_deframer_crc24q test failed");
    end
    $finish;
  end

  // hard stop if the handshakes never complete
  initial begin
    #5ms;
    $display("rtcm3_frame_deframer_crc24q test failed");
    $finish;
  end

endmodule
